// ===== rtl/core/big_endian_byte_ram_macros.svh =====
// assertion macros used by the port checker module of the byte ram
// no dependencies; included by file name where assertions are written
`ifndef BIG_ENDIAN_BYTE_RAM_MACROS_SVH
`define BIG_ENDIAN_BYTE_RAM_MACROS_SVH

// same-cycle implication, cancelled while reset is held
`define BEBR_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, cancelled while reset is held
`define BEBR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/bebr_pkg.sv =====
// types and constants of the big-endian byte ram
// request and response structs, command, size and status codes; no dependencies
package bebr_pkg;

    // command codes
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // supported access sizes in bytes
    localparam logic [3:0] SIZE_BYTE  = 4'd1;
    localparam logic [3:0] SIZE_WORD  = 4'd4;
    localparam logic [3:0] SIZE_DWORD = 4'd8;

    // response status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_SIZE = 2'd1;
    localparam logic [1:0] ST_RANGE    = 2'd2;

    // fill value of every byte after reset
    localparam logic [7:0] FILL_BYTE = 8'hFF;

    typedef struct packed {
        logic        command;
        logic [31:0] address;
        logic [3:0]  access_size;
        logic [63:0] write_data;
    } t_req;

    typedef struct packed {
        logic [63:0] read_data;
        logic [1:0]  status;
    } t_rsp;

endpackage

// ===== rtl/core/big_endian_byte_ram.sv =====
// Byte-addressed big-endian RAM of MEM_BYTES bytes, held in eight byte-wide banks
// (bank = address bits 2:0), so any 1, 4 or 8 byte access at any address touches each
// bank at most once. One request is taken per cycle while o_req_stall is low; its response
// is offered in the cycle after acceptance, set by the registered read port of the banks.
// Writes respond with zero data. After reset a clearing pass fills every byte with 0xFF,
// one row of eight bytes a cycle, during which o_req_stall is held high. A response waiting
// on i_rsp_stall holds off the next request. Depends on bebr_pkg.
module big_endian_byte_ram
    import bebr_pkg::*;
#(
    parameter int MEM_BYTES = 65536
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_stall,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_stall,
    output t_rsp o_rsp
);

    localparam int ROWS = (MEM_BYTES + 7) / 8;
    localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;

    // clearing pass state
    logic          r_clr_busy, n_clr_busy;
    logic [RW-1:0] r_clr_row, n_clr_row;

    // response stage
    logic       r_rsp_valid, n_rsp_valid;
    logic [1:0] r_status;
    logic       r_rd_ok;
    logic [2:0] r_off;
    logic [3:0] r_size;

    logic          w_accept;
    logic          w_size_ok;
    logic          w_range_ok;
    logic [32:0]   w_end;
    logic [1:0]    w_status;
    logic          w_go;
    logic [2:0]    w_off;
    logic [RW-1:0] w_row0;
    logic [7:0]    w_bank_q [8];
    logic [63:0]   w_seq;
    logic [63:0]   w_rdata;

    // handshake
    assign o_req_stall = r_clr_busy || (r_rsp_valid && i_rsp_stall);
    assign w_accept    = i_req_valid && !o_req_stall;

    // size and range checks; size takes precedence
    assign w_size_ok  = (i_req.access_size == SIZE_BYTE) || (i_req.access_size == SIZE_WORD)
                     || (i_req.access_size == SIZE_DWORD);
    assign w_end      = {1'b0, i_req.address} + {29'd0, i_req.access_size};
    assign w_range_ok = w_end <= 33'(MEM_BYTES);

    always_comb begin
        if (!w_size_ok) begin
            w_status = ST_BAD_SIZE;
        end else if (!w_range_ok) begin
            w_status = ST_RANGE;
        end else begin
            w_status = ST_OK;
        end
    end

    assign w_go   = w_accept && w_size_ok && w_range_ok;
    assign w_off  = i_req.address[2:0];
    assign w_row0 = i_req.address[RW+2:3];

    // eight byte banks, each with one port and a registered read
    for (genvar b = 0; b < 8; b++) begin : g_bank
        logic [7:0]    mem [ROWS];
        logic [7:0]    r_q;
        logic [2:0]    w_k;
        logic          w_use;
        logic [RW-1:0] w_row;
        logic [RW-1:0] w_addr;
        logic          w_we;
        logic          w_re;
        logic [7:0]    w_wdata;

        // byte position within the access that lands in this bank
        assign w_k    = 3'(b) - w_off;
        assign w_use  = {1'b0, w_k} < i_req.access_size;
        assign w_row  = (3'(b) < w_off) ? (w_row0 + RW'(1)) : w_row0;
        assign w_we   = r_clr_busy || (w_go && (i_req.command == CMD_WRITE) && w_use);
        assign w_re   = w_go && (i_req.command == CMD_READ) && w_use;
        assign w_addr = r_clr_busy ? r_clr_row : w_row;
        assign w_wdata = r_clr_busy ? FILL_BYTE : i_req.write_data[{~w_k, 3'b000} +: 8];

        always_ff @(posedge i_clk) begin
            if (w_we) begin
                mem[w_addr] <= w_wdata;
            end
            if (w_re) begin
                r_q <= mem[w_addr];
            end
        end

        assign w_bank_q[b] = r_q;
    end

    // clearing pass over all rows after reset
    always_comb begin
        n_clr_busy = r_clr_busy;
        n_clr_row  = r_clr_row;
        if (r_clr_busy) begin
            n_clr_row = r_clr_row + RW'(1);
            if (r_clr_row == RW'(ROWS - 1)) begin
                n_clr_busy = 1'b0;
            end
        end
    end

    // response valid: set on accept, cleared once taken
    always_comb begin
        if (w_accept) begin
            n_rsp_valid = 1'b1;
        end else if (i_rsp_stall) begin
            n_rsp_valid = r_rsp_valid;
        end else begin
            n_rsp_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy  <= 1'b1;
            r_clr_row   <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_clr_busy  <= n_clr_busy;
            r_clr_row   <= n_clr_row;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    // response payload context
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= w_status;
            r_rd_ok  <= w_go && (i_req.command == CMD_READ);
            r_off    <= w_off;
            r_size   <= i_req.access_size;
        end
    end

    // gather banks in address order, most significant byte first
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            w_seq[56 - 8 * k +: 8] = w_bank_q[3'(r_off + 3'(k))];
        end
    end

    // right-align by access size
    always_comb begin
        case (r_size)
            SIZE_BYTE: w_rdata = {56'd0, w_seq[63:56]};
            SIZE_WORD: w_rdata = {32'd0, w_seq[63:32]};
            default:   w_rdata = w_seq;
        endcase
        if (!r_rd_ok) begin
            w_rdata = '0;
        end
    end

    assign o_rsp_valid     = r_rsp_valid;
    assign o_rsp.read_data = w_rdata;
    assign o_rsp.status    = r_status;

endmodule

// ===== rtl/core/bebr_checker.sv =====
// port-level checks of the big-endian byte ram, bound to the top level
// depends on bebr_pkg and big_endian_byte_ram_macros.svh
`include "big_endian_byte_ram_macros.svh"

module bebr_port_checks
    import bebr_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_req_valid,
    input logic o_req_stall,
    input t_req i_req,
    input logic o_rsp_valid,
    input logic i_rsp_stall,
    input t_rsp o_rsp
);

    // every accepted request gets its response in the next cycle
    `BEBR_ASSERT_NEXT(a_rsp_latency, i_clk, i_rst_n,
        i_req_valid && !o_req_stall, o_rsp_valid,
        "no response one cycle after request")

    // a stalled response holds off new requests
    `BEBR_ASSERT_IMPLY(a_rsp_backpressure, i_clk, i_rst_n,
        o_rsp_valid && i_rsp_stall, o_req_stall,
        "request taken while response stalled")

    // failed accesses carry zero data
    `BEBR_ASSERT_IMPLY(a_err_zero, i_clk, i_rst_n,
        o_rsp_valid && (o_rsp.status != ST_OK), o_rsp.read_data == 64'd0,
        "error response with nonzero data")

    // stalled response stays put
    `BEBR_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n,
        o_rsp_valid && i_rsp_stall, o_rsp_valid && $stable(o_rsp),
        "stalled response changed")

endmodule

bind big_endian_byte_ram bebr_port_checks u_bebr_port_checks (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req_valid),
    .o_req_stall (o_req_stall),
    .i_req       (i_req),
    .o_rsp_valid (o_rsp_valid),
    .i_rsp_stall (i_rsp_stall),
    .o_rsp       (o_rsp)
);

// ===== tb/bebr_checker.sv =====
// checker of the big-endian byte ram: watches both channels, keeps a mirror
// of the memory, predicts every response and compares it; depends on bebr_pkg
module bebr_checker
    import bebr_pkg::*;
#(
    parameter int MEM_BYTES = 65536
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  logic req_stall,
    input  t_req req,
    input  logic rsp_valid,
    input  logic rsp_stall,
    input  t_rsp rsp,
    output int   n_fail,
    output int   n_pending
);

    logic [7:0] mirror_bytes [MEM_BYTES];
    t_rsp       rsp_due_q [$];
    t_rsp       due_rsp;

    // apply one request to the mirror and return the response it must give
    function automatic t_rsp apply_access(input t_req r);
        t_rsp        res;
        logic [32:0] end_addr;
        int          base;
        res      = '0;
        end_addr = {1'b0, r.address} + 33'(r.access_size);
        if (r.access_size != SIZE_BYTE && r.access_size != SIZE_WORD &&
            r.access_size != SIZE_DWORD) begin
            // size check wins over the range check
            res.status = ST_BAD_SIZE;
        end else if (end_addr > 33'(MEM_BYTES)) begin
            // no partial access and no wraparound
            res.status = ST_RANGE;
        end else begin
            base = int'(r.address);
            for (int i = 0; i < int'(r.access_size); i++) begin
                if (r.command == CMD_WRITE)
                    mirror_bytes[base + i] = r.write_data[63 - 8 * i -: 8];
                else
                    res.read_data = {res.read_data[55:0], mirror_bytes[base + i]};
            end
            res.status = ST_OK;
        end
        return res;
    endfunction

    // track requests and compare responses in order
    always @(posedge clk) begin
        if (!rst_n) begin
            foreach (mirror_bytes[a]) mirror_bytes[a] = FILL_BYTE;
            rsp_due_q.delete();
            n_fail = 0;
        end else begin
            if (rsp_valid && !rsp_stall) begin
                if (rsp_due_q.size() == 0) begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("unexpected response: read_data %h, status %0d",
                                 rsp.read_data, rsp.status);
                end else begin
                    due_rsp = rsp_due_q.pop_front();
                    if (rsp.read_data !== due_rsp.read_data ||
                        rsp.status !== due_rsp.status) begin
                        n_fail++;
                        if (n_fail <= 10)
                            $display("mismatch at %0t: expected read_data %h status %0d, %s",
                                     $realtime, due_rsp.read_data, due_rsp.status,
                                     $sformatf("got read_data %h status %0d",
                                               rsp.read_data, rsp.status));
                    end
                end
            end
            if (req_valid && !req_stall)
                rsp_due_q.push_back(apply_access(req));
        end
        n_pending = rsp_due_q.size();
    end

endmodule

// ===== tb/tb.sv =====
// testbench top of the big-endian byte ram: clock, reset, request stimulus
// and response back-pressure; depends on bebr_pkg, big_endian_byte_ram, bebr_checker
module tb;
    import bebr_pkg::*;

    localparam int MEM_BYTES = 65536;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    t_req req       = '0;
    logic rsp_stall = 1'b0;
    logic req_stall;
    logic rsp_valid;
    t_rsp rsp;
    int   n_fail;
    int   n_pending;

    // idling limits, changed per phase
    int   max_gap   = 5;
    int   max_stall = 5;
    int   stall_left = 0;
    logic rsp_fired  = 1'b0;

    big_endian_byte_ram #(
        .MEM_BYTES(MEM_BYTES)
    ) DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_req_valid(req_valid),
        .o_req_stall(req_stall),
        .i_req      (req),
        .o_rsp_valid(rsp_valid),
        .i_rsp_stall(rsp_stall),
        .o_rsp      (rsp)
    );

    bebr_checker #(
        .MEM_BYTES(MEM_BYTES)
    ) u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp),
        .n_fail   (n_fail),
        .n_pending(n_pending)
    );

    // clock, period of two units
    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // present one request after a random gap and hold it until taken
    task automatic send_access(input logic cmd, input logic [31:0] addr,
                               input logic [3:0] size, input logic [63:0] data);
        int gap;
        gap = $urandom_range(0, max_gap);
        @(negedge clk);
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= '{command: cmd, address: addr, access_size: size, write_data: data};
        @(posedge clk);
        while (req_stall) @(posedge clk);
    endtask

    // response back-pressure: a fresh stall count after every taken response
    always @(posedge clk) rsp_fired = rsp_valid && !rsp_stall;

    always @(negedge clk) begin
        if (rsp_fired) stall_left = $urandom_range(0, max_stall);
        if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
        end else begin
            rsp_stall <= 1'b0;
        end
    end

    // stimulus and verdict
    initial begin
        logic [31:0] addr;
        logic [3:0]  size;
        int          sel;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // fresh memory reads back as fill bytes
        send_access(CMD_READ,  32'd0,     SIZE_DWORD, 64'h0);
        send_access(CMD_READ,  32'd65535, SIZE_BYTE,  64'h0);
        // aligned and unaligned writes with read-back
        send_access(CMD_WRITE, 32'd0,     SIZE_DWORD, 64'h0123_4567_89AB_CDEF);
        send_access(CMD_READ,  32'd0,     SIZE_DWORD, 64'h0);
        send_access(CMD_READ,  32'd2,     SIZE_WORD,  64'hFFFF_FFFF_FFFF_FFFF);
        send_access(CMD_WRITE, 32'd1,     SIZE_BYTE,  64'hA53C_3C3C_3C3C_3C3C);
        send_access(CMD_READ,  32'd0,     SIZE_DWORD, 64'h0);
        send_access(CMD_WRITE, 32'd5,     SIZE_WORD,  64'hDEAD_BEEF_FFFF_FFFF);
        send_access(CMD_READ,  32'd3,     SIZE_DWORD, 64'h0);
        // last bytes that still fit
        send_access(CMD_WRITE, 32'd65528, SIZE_DWORD, 64'h0);
        send_access(CMD_READ,  32'd65528, SIZE_DWORD, 64'h0);
        send_access(CMD_WRITE, 32'd65532, SIZE_WORD,  64'hFFFF_FFFF_0000_0000);
        send_access(CMD_READ,  32'd65532, SIZE_WORD,  64'h0);
        send_access(CMD_WRITE, 32'd65535, SIZE_BYTE,  64'h5A00_0000_0000_0000);
        send_access(CMD_READ,  32'd65535, SIZE_BYTE,  64'h0);
        // accesses running past the end
        send_access(CMD_READ,  32'd65529, SIZE_DWORD, 64'h0);
        send_access(CMD_WRITE, 32'd65533, SIZE_WORD,  64'h1234_5678_0000_0000);
        send_access(CMD_READ,  32'd65536, SIZE_BYTE,  64'h0);
        send_access(CMD_WRITE, 32'hFFFF_FFFF, SIZE_DWORD, 64'hFFFF_FFFF_FFFF_FFFF);
        // unsupported sizes, also ahead of an out-of-range address
        send_access(CMD_READ,  32'd0,     4'd0,  64'h0);
        send_access(CMD_WRITE, 32'd0,     4'd2,  64'hFFFF_FFFF_FFFF_FFFF);
        send_access(CMD_READ,  32'hFFFF_FFFF, 4'd15, 64'h0);
        send_access(CMD_WRITE, 32'd0,     4'd3,  64'h0);
        send_access(CMD_READ,  32'd0,     SIZE_DWORD, 64'h0);

        // random phases, cycling through four idling patterns
        for (int ph = 0; ph < 7; ph++) begin
            case (ph % 4)
                0: begin max_gap = 5; max_stall = 5; end
                1: begin max_gap = 0; max_stall = 0; end
                2: begin max_gap = 5; max_stall = 0; end
                default: begin max_gap = 0; max_stall = 5; end
            endcase
            repeat (250) begin
                // mostly a small window so reads hit written bytes
                sel = $urandom_range(0, 99);
                if (sel < 50)
                    addr = $urandom_range(0, 255);
                else if (sel < 75)
                    addr = MEM_BYTES - 72 + $urandom_range(0, 71);
                else if (sel < 90)
                    addr = $urandom_range(0, MEM_BYTES - 1);
                else
                    addr = $urandom();
                // mostly supported sizes, the rest any 4-bit value
                if ($urandom_range(0, 9) < 8) begin
                    case ($urandom_range(0, 2))
                        0:       size = SIZE_BYTE;
                        1:       size = SIZE_WORD;
                        default: size = SIZE_DWORD;
                    endcase
                end else begin
                    size = 4'($urandom_range(0, 15));
                end
                send_access($urandom_range(0, 1) ? CMD_WRITE : CMD_READ, addr, size,
                            {$urandom(), $urandom()});
            end
        end

        @(negedge clk);
        req_valid <= 1'b0;
        // drain outstanding responses, then a short tail
        max_stall = 0;
        while (n_pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (n_fail == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // run limit
    initial begin
        #600000;
        $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/bebr_pkg.sv
rtl/core/big_endian_byte_ram.sv
rtl/core/bebr_checker.sv
tb/bebr_checker.sv
tb/tb.sv
